// ----- hdl/pcpfl_pkg.sv -----
// ----------------------------------------------------------------------------
// pcpfl_pkg
// shared types and codes for the per-cpu page free list allocator
// ----------------------------------------------------------------------------
package pcpfl_pkg;

    // request modes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_OOM     = 2'd1;
    localparam logic [1:0] ST_BADADDR = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_START = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_END   = 4'd1;

    localparam logic [31:0] REGION_START_RST = 32'h8000_0000;
    localparam logic [31:0] REGION_END_RST   = 32'h8800_0000;

    typedef struct packed {
        logic        mode;
        logic [2:0]  cpu;
        logic [31:0] page_addr;
    } pcpfl_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] alloc_addr;
        logic [2:0]  source_cpu;
    } pcpfl_result_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic free_fin;
        logic link_rd;
        logic pop_fin;
        logic oom_fin;
    } pcpfl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_free;
        logic found;
    } pcpfl_sts_t;

endpackage

// ----- hdl/pcpfl_ram.sv -----
// ----------------------------------------------------------------------------
// pcpfl_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module pcpfl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/pcpfl_ctrl.sv -----
// ----------------------------------------------------------------------------
// pcpfl_ctrl
// sequencer for free, pop and out-of-memory requests
// ----------------------------------------------------------------------------
module pcpfl_ctrl
    import pcpfl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  pcpfl_sts_t sts,
    output pcpfl_cmd_t cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FREE  = 3'd1;
    localparam logic [2:0] S_AHEAD = 3'd2;
    localparam logic [2:0] S_APOP  = 3'd3;
    localparam logic [2:0] S_NOMEM = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg) inside
            S_IDLE:
            begin
                if (start)
                begin
                    if (sts.is_free)
                    begin
                        state_next = S_FREE;
                    end
                    else if (sts.found)
                    begin
                        state_next = S_AHEAD;
                    end
                    else
                    begin
                        state_next = S_NOMEM;
                    end
                end
            end
            S_AHEAD: state_next = S_APOP;
            S_FREE, S_APOP, S_NOMEM: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign cmd.accept   = (state_reg == S_IDLE) && start;
    assign cmd.free_fin = (state_reg == S_FREE);
    assign cmd.link_rd  = (state_reg == S_AHEAD);
    assign cmd.pop_fin  = (state_reg == S_APOP);
    assign cmd.oom_fin  = (state_reg == S_NOMEM);

    // only one phase of work at a time
    a_one_phase: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.free_fin, cmd.link_rd, cmd.pop_fin, cmd.oom_fin}))
        else $error("more than one controller phase active");

    // a pop finishes only after its link read
    a_pop_after_link: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_fin |-> $past(cmd.link_rd))
        else $error("pop finished without a link read");

    // an accepted alloc with no list goes straight to out of memory
    a_oom_path: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && !sts.is_free && !sts.found) |=> cmd.oom_fin)
        else $error("empty alloc did not report out of memory");

endmodule

// ----- hdl/pcpfl_dp.sv -----
// ----------------------------------------------------------------------------
// pcpfl_dp
// head and link memories, address checks, config registers and result
// ----------------------------------------------------------------------------
module pcpfl_dp
    import pcpfl_pkg::*;
#(
    parameter int CPU_COUNT  = 8,
    parameter int MAX_PAGES  = 32768,
    parameter int PAGE_SHIFT = 12,
    parameter int ADDR_BITS  = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pcpfl_item_t          item,
    input  pcpfl_cmd_t           cmd,
    output pcpfl_sts_t           sts,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output logic                 done,
    output pcpfl_result_t        result
);

    localparam int CIW = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
    localparam int PGW = $clog2(MAX_PAGES);
    localparam logic [31:0] OFS_MASK = 32'((64'd1 << PAGE_SHIFT) - 64'd1);
    localparam logic [31:0] ADDR_MASK =
        (ADDR_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDR_BITS) - 64'd1);

    logic [31:0]          region_start_reg;
    logic [31:0]          region_end_reg;
    logic [CPU_COUNT-1:0] hv_reg;
    logic [CIW-1:0]       cpu_reg;
    logic [31:0]          addr_reg;
    logic [PGW-1:0]       pg_reg;
    logic                 done_reg;
    pcpfl_result_t        result_reg;

    logic [CIW-1:0] cpu_m;
    logic [CIW-1:0] first_idx;
    logic           any_valid;
    logic [CIW-1:0] src;
    logic [CIW-1:0] head_raddr;
    logic [PGW-1:0] head_q;
    logic [PGW:0]   link_q;

    logic           head_we;
    logic [PGW-1:0] head_wdata;
    logic           link_we;
    logic [PGW:0]   link_wdata;

    logic [31:0] base_pn;
    logic [31:0] idx32;
    logic        bad_addr;
    logic [31:0] pop_addr;

    // cpu number taken modulo the cpu count
    function automatic logic [CIW-1:0] cpu_wrap(input logic [2:0] c);
        logic [6:0] v;
        v = {4'd0, c};
        for (int i = 0; i < 8; i++)
        begin
            if (v >= 7'(CPU_COUNT))
            begin
                v = v - 7'(CPU_COUNT);
            end
        end
        return CIW'(v);
    endfunction

    assign cpu_m = cpu_wrap(item.cpu);

    // lowest numbered non-empty list
    always_comb
    begin
        first_idx = '0;
        any_valid = 1'b0;
        for (int i = 0; i < CPU_COUNT; i++)
        begin
            if (hv_reg[i] && !any_valid)
            begin
                first_idx = CIW'(i);
                any_valid = 1'b1;
            end
        end
    end

    assign src         = hv_reg[cpu_m] ? cpu_m : first_idx;
    assign head_raddr  = (item.mode == MODE_FREE) ? cpu_m : src;
    assign sts.is_free = (item.mode == MODE_FREE);
    assign sts.found   = any_valid;

    // free address checks
    assign base_pn  = region_start_reg >> PAGE_SHIFT;
    assign idx32    = (addr_reg >> PAGE_SHIFT) - base_pn;
    assign bad_addr = ((addr_reg & OFS_MASK) != 32'd0)
                   || (addr_reg < region_start_reg)
                   || (addr_reg >= region_end_reg)
                   || (idx32 >= 32'(MAX_PAGES));

    // pages are rebased on the current region start when popped
    assign pop_addr = ((base_pn + 32'(pg_reg)) << PAGE_SHIFT) & ADDR_MASK;

    always_comb
    begin
        head_we    = 1'b0;
        head_wdata = idx32[PGW-1:0];
        link_we    = cmd.free_fin && !bad_addr;
        link_wdata = {hv_reg[cpu_reg], hv_reg[cpu_reg] ? head_q : '0};
        if (cmd.free_fin && !bad_addr)
        begin
            head_we = 1'b1;
        end
        else if (cmd.pop_fin)
        begin
            head_we    = link_q[PGW];
            head_wdata = link_q[PGW-1:0];
        end
    end

    pcpfl_ram #(
        .WIDTH (PGW),
        .DEPTH (CPU_COUNT)
    ) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (cpu_reg),
        .wdata (head_wdata),
        .re    (cmd.accept),
        .raddr (head_raddr),
        .rdata (head_q)
    );

    pcpfl_ram #(
        .WIDTH (PGW + 1),
        .DEPTH (MAX_PAGES)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (idx32[PGW-1:0]),
        .wdata (link_wdata),
        .re    (cmd.link_rd),
        .raddr (head_q),
        .rdata (link_q)
    );

    // control state: config, list valid bits, result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_start_reg <= REGION_START_RST;
            region_end_reg   <= REGION_END_RST;
            hv_reg           <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_REGION_START: region_start_reg <= cfg_data;
                    REG_REGION_END:   region_end_reg   <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.free_fin && !bad_addr)
            begin
                hv_reg[cpu_reg] <= 1'b1;
            end
            else if (cmd.pop_fin)
            begin
                hv_reg[cpu_reg] <= link_q[PGW];
            end
            done_reg <= cmd.free_fin || cmd.pop_fin || cmd.oom_fin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cpu_reg  <= head_raddr;
            addr_reg <= item.page_addr;
        end
        if (cmd.link_rd)
        begin
            pg_reg <= head_q;
        end
        if (cmd.free_fin)
        begin
            result_reg.status     <= bad_addr ? ST_BADADDR : ST_DONE;
            result_reg.alloc_addr <= 32'd0;
            result_reg.source_cpu <= 3'd0;
        end
        else if (cmd.oom_fin)
        begin
            result_reg.status     <= ST_OOM;
            result_reg.alloc_addr <= 32'd0;
            result_reg.source_cpu <= 3'd0;
        end
        else if (cmd.pop_fin)
        begin
            result_reg.status     <= ST_DONE;
            result_reg.alloc_addr <= pop_addr;
            result_reg.source_cpu <= 3'(cpu_reg);
        end
    end

    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

endmodule

// ----- hdl/per_cpu_page_free_list_allocator.sv -----
// ----------------------------------------------------------------------------
// per_cpu_page_free_list_allocator
// per-cpu lifo page free lists with a shared link memory
// ----------------------------------------------------------------------------
//  channel   direction  handshake                     payload
//  request   in         start & !busy                 item (mode, cpu, page_addr)
//  result    out        done, one cycle, no stall     result (status, alloc_addr,
//                                                     source_cpu)
//  config    in         cfg_valid & cfg_ready         cfg_index, cfg_data
//
//  free and out-of-memory requests are accepted and then finished; an allocate
//  that finds a page goes through head memory read, then link memory read,
//  then head update. the result shows in the cycle after the last of these;
//  busy is already low then, so the next request overlaps with it.
//  after reset all lists are empty and the region is 0x80000000..0x88000000.
//  results cannot be stalled; cfg_ready is always high.
// ----------------------------------------------------------------------------
module per_cpu_page_free_list_allocator
    import pcpfl_pkg::*;
#(
    parameter int CPU_COUNT  = 8,
    parameter int MAX_PAGES  = 32768,
    parameter int PAGE_SHIFT = 12,
    parameter int ADDR_BITS  = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  pcpfl_item_t          item,
    output logic                 done,
    output pcpfl_result_t        result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    pcpfl_cmd_t cmd;
    pcpfl_sts_t sts;

    pcpfl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    pcpfl_dp #(
        .CPU_COUNT  (CPU_COUNT),
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT),
        .ADDR_BITS  (ADDR_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

endmodule

// ----- verif/tb_per_cpu_page_free_list_allocator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_per_cpu_page_free_list_allocator
// self-checking bench for the per-cpu page free list allocator: an internal
// model of the head registers and link memory predicts every result, requests
// mix well-formed free/alloc traffic with bad addresses across several region
// settings, and the request side idles in random bursts
// ----------------------------------------------------------------------------
module tb_per_cpu_page_free_list_allocator;
    import pcpfl_pkg::*;

    localparam int CPU_COUNT    = 8;
    localparam int MAX_PAGES    = 32768;
    localparam int PAGE_SHIFT   = 12;
    localparam int ADDR_BITS    = 32;
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES   = 8;
    localparam int END_WAIT_MAX = 1000;
    localparam int MAX_PRINTED  = 40;
    localparam longint TIMEOUT_NS = 2_000_000;

    class page_alloc_scoreboard;
        logic [31:0]   region_start;
        logic [31:0]   region_end;
        bit            head_ok [CPU_COUNT];
        logic [15:0]   head_pg [CPU_COUNT];
        bit            link_ok [MAX_PAGES];
        logic [15:0]   link_pg [MAX_PAGES];
        pcpfl_result_t expected_results[$];
        logic [31:0]   held_pages[$];
        int            listed_pages;
        int            errors;
        int            n_alloc;
        int            n_stolen;
        int            n_oom;
        int            n_pushed;
        int            n_rejected;

        function new();
            region_start = REGION_START_RST;
            region_end   = REGION_END_RST;
            foreach (head_pg[i])
            begin
                head_ok[i] = 1'b0;
                head_pg[i] = '0;
            end
        endfunction

        function void set_region(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
            if (idx == REG_REGION_START)
                region_start = value;
            else if (idx == REG_REGION_END)
                region_end = value;
        endfunction

        function bit addr_ok(logic [31:0] a);
            logic [31:0] idx;
            if (a[PAGE_SHIFT-1:0] != '0 || a < region_start || a >= region_end)
                return 1'b0;
            idx = (a >> PAGE_SHIFT) - (region_start >> PAGE_SHIFT);
            return idx < MAX_PAGES;
        endfunction

        // push or pop on the lists and work out the result
        function pcpfl_result_t apply_request(pcpfl_item_t it);
            pcpfl_result_t r;
            int            c;
            int            src;
            int            i;
            logic [31:0]   idx;
            logic [15:0]   pg;
            logic [63:0]   addr64;
            r = '0;
            c = int'(it.cpu) % CPU_COUNT;
            if (it.mode == MODE_FREE)
            begin
                if (!addr_ok(it.page_addr))
                begin
                    r.status = ST_BADADDR;
                    n_rejected++;
                    return r;
                end
                idx = (it.page_addr >> PAGE_SHIFT) - (region_start >> PAGE_SHIFT);
                link_ok[idx] = head_ok[c];
                link_pg[idx] = head_ok[c] ? head_pg[c] : '0;
                head_ok[c] = 1'b1;
                head_pg[c] = idx[15:0];
                listed_pages++;
                n_pushed++;
                r.status = ST_DONE;
                return r;
            end
            src = head_ok[c] ? c : -1;
            for (i = 0; i < CPU_COUNT; i++)
                if (src < 0 && i != c && head_ok[i])
                    src = i;
            if (src < 0)
            begin
                r.status = ST_OOM;
                n_oom++;
                return r;
            end
            pg = 16'(head_pg[src] % MAX_PAGES);
            head_ok[src] = link_ok[pg];
            head_pg[src] = link_ok[pg] ? link_pg[pg] : '0;
            // listed page numbers are rebased on the current region
            addr64 = (64'(region_start >> PAGE_SHIFT) + 64'(pg)) << PAGE_SHIFT;
            addr64 = addr64 & ((64'd1 << ADDR_BITS) - 64'd1);
            r.status     = ST_DONE;
            r.alloc_addr = addr64[31:0];
            r.source_cpu = src[2:0];
            listed_pages--;
            n_alloc++;
            if (src != c)
                n_stolen++;
            held_pages.push_back(addr64[31:0]);
            return r;
        endfunction

        function void note_request(pcpfl_item_t it);
            expected_results.push_back(apply_request(it));
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("%0t mismatch: %s", $time, msg);
        endtask

        task check_result(pcpfl_result_t got);
            pcpfl_result_t want;
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result status %0d addr %h cpu %0d",
                                          got.status, got.alloc_addr, got.source_cpu));
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, expected %0d",
                                          got.status, want.status));
            if (got.alloc_addr !== want.alloc_addr)
                report_mismatch($sformatf("alloc_addr %h, expected %h",
                                          got.alloc_addr, want.alloc_addr));
            if (got.source_cpu !== want.source_cpu)
                report_mismatch($sformatf("source_cpu %0d, expected %0d",
                                          got.source_cpu, want.source_cpu));
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    pcpfl_item_t          req_item;
    logic                 done;
    pcpfl_result_t        res;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    page_alloc_scoreboard sb = new();
    bit                   fresh_used[int];
    int                   n_regions = 1;

    per_cpu_page_free_list_allocator #(
        .CPU_COUNT  (CPU_COUNT),
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT),
        .ADDR_BITS  (ADDR_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (req_item),
        .done      (done),
        .result    (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            sb.check_result(res);
    end

    function automatic pcpfl_item_t make_alloc(logic [2:0] cpu);
        pcpfl_item_t it;
        it.mode      = MODE_ALLOC;
        it.cpu       = cpu;
        it.page_addr = $urandom;
        return it;
    endfunction

    function automatic pcpfl_item_t make_free(logic [2:0] cpu, logic [31:0] addr);
        pcpfl_item_t it;
        it.mode      = MODE_FREE;
        it.cpu       = cpu;
        it.page_addr = addr;
        return it;
    endfunction

    // a page of the current region that has not been handed out in this phase
    function automatic bit pick_fresh(output logic [31:0] addr);
        longint base;
        longint span;
        longint cand;
        int     k;
        int     tries;
        addr = '0;
        base = longint'(sb.region_start >> PAGE_SHIFT);
        span = ((longint'(sb.region_end) + (longint'(1) << PAGE_SHIFT) - 1) >> PAGE_SHIFT)
               - base;
        if (span > MAX_PAGES)
            span = MAX_PAGES;
        for (tries = 0; tries < 16 && span > 0; tries++)
        begin
            k = $urandom_range(0, int'(span) - 1);
            cand = (base + k) << PAGE_SHIFT;
            if (!fresh_used.exists(k) && cand < 64'h1_0000_0000 && sb.addr_ok(cand[31:0]))
            begin
                fresh_used[k] = 1'b1;
                addr = cand[31:0];
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic pcpfl_item_t next_random_request();
        pcpfl_item_t it;
        logic [31:0] a;
        longint      cand;
        int          pick;
        int          n;
        it   = make_alloc(3'($urandom_range(0, CPU_COUNT - 1)));
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            if (pick_fresh(a))
                it = make_free(it.cpu, a);
        end
        else if (pick < 45)
        begin
            // hand back a page this phase allocated
            if (sb.held_pages.size() != 0)
            begin
                n = $urandom_range(0, sb.held_pages.size() - 1);
                it = make_free(it.cpu, sb.held_pages[n]);
                sb.held_pages.delete(n);
            end
        end
        else if (pick < 60)
        begin
            n = $urandom_range(0, 4);
            if (n == 0)
                cand = $urandom;
            else if (n == 1)
                cand = (longint'(sb.region_start) & ~longint'(32'hFFF))
                       + (longint'($urandom_range(0, 63)) << PAGE_SHIFT)
                       + $urandom_range(1, (1 << PAGE_SHIFT) - 1);
            else if (n == 2)
                cand = (sb.region_start == 0) ? longint'($urandom)
                       : longint'($urandom_range(0, sb.region_start - 1));
            else if (n == 3)
                cand = $urandom_range(0, 1) ? longint'(sb.region_end)
                       : longint'($urandom_range(sb.region_end, 32'hFFFF_FFFF));
            else
                cand = ((longint'(sb.region_start) >> PAGE_SHIFT) + MAX_PAGES
                        + $urandom_range(0, 3)) << PAGE_SHIFT;
            a = cand[31:0];
            // keep it a bad address
            if (sb.addr_ok(a))
                a[0] = 1'b1;
            it = make_free(it.cpu, a);
        end
        return it;
    endfunction

    task automatic send_request(pcpfl_item_t it);
        @(negedge clk);
        start    <= 1'b1;
        req_item <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(it);
    endtask

    task automatic maybe_idle(bit allow);
        if (allow && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 14))
            begin
                @(negedge clk);
                start <= 1'b0;
            end
    endtask

    task automatic wait_all_results();
        @(negedge clk);
        start <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_region(idx, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_region(logic [31:0] lo, logic [31:0] hi);
        wait_all_results();
        repeat (SETTLE_CYCLES)
            @(negedge clk);
        write_cfg(REG_REGION_START, lo);
        write_cfg(REG_REGION_END, hi);
        n_regions++;
    endtask

    task automatic run_phase(int n_items, bit allow_idle);
        int          i;
        logic [31:0] a;
        // pages left listed by the last region come back rebased on this one
        while (sb.listed_pages > 0)
        begin
            maybe_idle(allow_idle);
            send_request(make_alloc(3'($urandom_range(0, CPU_COUNT - 1))));
        end
        repeat (2)
            send_request(make_alloc(3'($urandom_range(0, CPU_COUNT - 1))));
        sb.held_pages.delete();
        fresh_used.delete();
        for (i = 0; i < n_items; i++)
        begin
            if (i == n_items / 2)
                wait_all_results();
            maybe_idle(allow_idle);
            send_request(next_random_request());
        end
        // leave a few pages listed across the next region change
        repeat (3)
            if (pick_fresh(a))
                send_request(make_free(3'($urandom_range(0, CPU_COUNT - 1)), a));
    endtask

    initial
    begin
        #(TIMEOUT_NS);
        $display("tb_per_cpu_page_free_list_allocator NOT OK");
        $finish;
    end

    initial
    begin
        int          wait_cnt;
        logic [31:0] lo;
        rst_n     = 1'b0;
        start     = 1'b0;
        req_item  = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty lists
        send_request(make_alloc(3'd0));
        send_request(make_alloc(3'd7));
        // misaligned, below the region, at its end, top and bottom of the space
        send_request(make_free(3'd1, 32'h8000_0001));
        send_request(make_free(3'd1, 32'h7FFF_F000));
        send_request(make_free(3'd2, 32'h8800_0000));
        send_request(make_free(3'd3, 32'hFFFF_FFFF));
        send_request(make_free(3'd4, 32'h0000_0000));
        // first and last page, own pops in lifo order, then a steal
        send_request(make_free(3'd0, 32'h8000_0000));
        send_request(make_free(3'd7, 32'h87FF_F000));
        send_request(make_free(3'd0, 32'h8000_1000));
        send_request(make_alloc(3'd0));
        send_request(make_alloc(3'd0));
        send_request(make_alloc(3'd0));
        send_request(make_alloc(3'd3));
        // same page freed on two cpus
        send_request(make_free(3'd2, 32'h8000_2000));
        send_request(make_free(3'd3, 32'h8000_2000));
        send_request(make_alloc(3'd2));
        send_request(make_alloc(3'd3));
        send_request(make_alloc(3'd5));
        // steal goes to the lowest non-empty list
        send_request(make_free(3'd6, 32'h8000_6000));
        send_request(make_free(3'd5, 32'h8000_5000));
        send_request(make_alloc(3'd1));
        send_request(make_alloc(3'd4));

        run_phase(60, 1'b1);
        load_region(32'h0000_0000, 32'hFFFF_FFFF);
        run_phase(60, 1'b1);
        // single page at the top; pages listed above wrap when rebased
        load_region(32'hFFFF_F000, 32'hFFFF_FFFF);
        run_phase(60, 1'b1);
        load_region(32'h1234_5678, 32'h1236_5678);
        run_phase(60, 1'b1);
        load_region(32'h4000_0000, 32'h0000_0000);
        run_phase(40, 1'b1);
        lo = $urandom & 32'hFFFF_F000;
        load_region(lo, lo + ($urandom_range(1, 64) << PAGE_SHIFT));
        run_phase(60, 1'b1);
        load_region(REGION_START_RST, REGION_END_RST);
        run_phase(70, 1'b0);

        @(negedge clk);
        start <= 1'b0;
        wait_cnt = 0;
        while (sb.expected_results.size() != 0 && wait_cnt < END_WAIT_MAX)
        begin
            @(negedge clk);
            wait_cnt++;
        end
        repeat (END_CYCLES)
            @(negedge clk);
        if (sb.expected_results.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived",
                                         sb.expected_results.size()));

        $display("covered %0d allocations (%0d taken from another cpu), %0d out of memory",
                 sb.n_alloc, sb.n_stolen, sb.n_oom);
        $display("covered %0d pages freed and %0d frees rejected over %0d region settings",
                 sb.n_pushed, sb.n_rejected, n_regions);
        if (sb.errors == 0)
            $display("tb_per_cpu_page_free_list_allocator OK");
        else
            $display("tb_per_cpu_page_free_list_allocator NOT OK");
        $finish;
    end

endmodule
